// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of the list engine.
// Depends on nothing; included by the checker that binds to the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define DLL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define DLL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dllce_pkg.sv =====
// Shared types and command codes of the linked-list cursor engine.
// Depends on nothing; imported by the engine and its checker.
package dllce_pkg;

  localparam int NODES_DEF = 16;

  localparam logic [4:0] CMD_CLEAR      = 5'd0;
  localparam logic [4:0] CMD_INS_FIRST  = 5'd1;
  localparam logic [4:0] CMD_INS_LAST   = 5'd2;
  localparam logic [4:0] CMD_CUR_FIRST  = 5'd3;
  localparam logic [4:0] CMD_CUR_LAST   = 5'd4;
  localparam logic [4:0] CMD_RD_FIRST   = 5'd5;
  localparam logic [4:0] CMD_RD_LAST    = 5'd6;
  localparam logic [4:0] CMD_DEL_FIRST  = 5'd7;
  localparam logic [4:0] CMD_DEL_LAST   = 5'd8;
  localparam logic [4:0] CMD_DEL_AFTER  = 5'd9;
  localparam logic [4:0] CMD_DEL_BEFORE = 5'd10;
  localparam logic [4:0] CMD_INS_AFTER  = 5'd11;
  localparam logic [4:0] CMD_INS_BEFORE = 5'd12;
  localparam logic [4:0] CMD_READ       = 5'd13;
  localparam logic [4:0] CMD_WRITE      = 5'd14;
  localparam logic [4:0] CMD_NEXT       = 5'd15;
  localparam logic [4:0] CMD_PREV       = 5'd16;

  typedef struct packed {
    logic [4:0]         func;
    logic signed [31:0] value_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic               error;
    logic               cursor_valid;
    logic               list_empty;
    logic               pool_full;
  } out_t;

endpackage

// ===== rtl/doubly_linked_list_cursor_engine_unit.sv =====
// Linked-list cursor engine: pool-based doubly linked list with head, tail, cursor.
// Depends on dllce_pkg (command codes, transaction structs).
//
// Usage:
//   Command channel: drive in_data and raise start; the transaction is taken at a
//   rising edge where start is high and busy is low. busy stays high while the
//   command walks through the link memories.
//   Result channel: out_valid pulses for one cycle with out_data; there is no
//   back-pressure, the receiver must take it in that cycle.
//   Sequence: the result is registered at the end of state A for most commands,
//   and after state B for an insert that links into a non-empty list and for a
//   delete beside the cursor that removes an entry. A new command is taken only
//   once the last one is through. The rate is set by the registered reads of the
//   link memories: a delete beside the cursor needs two dependent link reads, an
//   insert needs two writes on the same link memory. busy drops in the cycle the
//   result is shown, so the next command can be taken then.
//   Reset: head, tail and cursor become null, every pool entry is free. The
//   value and link memories are not cleared; each entry is written when it is
//   taken from the pool.
module doubly_linked_list_cursor_engine_unit #(
  parameter int NODES = dllce_pkg::NODES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  dllce_pkg::in_t  in_data,
  output logic            out_valid,
  output dllce_pkg::out_t out_data
);
  import dllce_pkg::*;

  localparam int IW = $clog2(NODES + 1);
  localparam int AW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam logic [IW-1:0] NIL = IW'(NODES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_A    = 2'd1;
  localparam logic [1:0] ST_B    = 2'd2;

  function automatic logic live(input logic [IW-1:0] idx);
    return idx < NIL;
  endfunction

  // Storage
  logic [31:0]   val_mem [NODES];
  logic [IW-1:0] fwd_mem [NODES];
  logic [IW-1:0] bwd_mem [NODES];
  logic [31:0]   val_q;
  logic [IW-1:0] fwd_q;
  logic [IW-1:0] bwd_q;

  // Control state
  logic [1:0]       state_r, state_nxt;
  logic [IW-1:0]    head_r, head_nxt;
  logic [IW-1:0]    tail_r, tail_nxt;
  logic [IW-1:0]    cur_r, cur_nxt;
  logic [NODES-1:0] occ_r, occ_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Per-command payload
  logic [4:0]    cmd_r, cmd_nxt;
  logic [31:0]   wval_r, wval_nxt;
  logic [IW-1:0] new_r, new_nxt;
  logic [IW-1:0] lnk_r, lnk_nxt;
  out_t          out_r, out_nxt;

  // Memory port controls
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          val_we, fwd_we, bwd_we;
  logic [IW-1:0] val_wa, fwd_wa, bwd_wa;
  logic [31:0]   val_wd;
  logic [IW-1:0] fwd_wd, bwd_wd;

  logic [IW-1:0] free_idx;
  logic          full;
  logic [IW-1:0] sel;
  logic [31:0]   rd_data;
  logic          err;
  logic          fin;

  // Lowest free pool entry
  always_comb begin
    free_idx = NIL;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (!occ_r[i]) free_idx = IW'(i);
    end
  end

  assign full = (cnt_r == CW'(NODES));

  always_comb begin
    case (in_data.func)
      CMD_RD_FIRST, CMD_DEL_FIRST: sel = head_r;
      CMD_RD_LAST, CMD_DEL_LAST:   sel = tail_r;
      default:                     sel = cur_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cur_nxt       = cur_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    wval_nxt      = wval_r;
    new_nxt       = new_r;
    lnk_nxt       = lnk_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = sel;
    val_we        = 1'b0;
    fwd_we        = 1'b0;
    bwd_we        = 1'b0;
    val_wa        = free_idx;
    fwd_wa        = free_idx;
    bwd_wa        = free_idx;
    val_wd        = wval_r;
    fwd_wd        = NIL;
    bwd_wd        = NIL;
    rd_data       = '0;
    err           = 1'b0;
    fin           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt   = in_data.func;
          wval_nxt  = in_data.value_in;
          rd_en     = live(sel);
          state_nxt = ST_A;
        end
      end

      ST_A: begin
        new_nxt = free_idx;
        case (cmd_r)
          CMD_CLEAR: begin
            occ_nxt  = '0;
            cnt_nxt  = '0;
            head_nxt = NIL;
            tail_nxt = NIL;
            cur_nxt  = NIL;
            fin      = 1'b1;
          end
          CMD_INS_FIRST, CMD_INS_LAST: begin
            if (full) begin
              err = 1'b1;
              fin = 1'b1;
            end else begin
              val_we = 1'b1;
              fwd_we = 1'b1;
              bwd_we = 1'b1;
              occ_nxt[free_idx[AW-1:0]] = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
              if (cmd_r == CMD_INS_FIRST) begin
                fwd_wd   = head_r;
                head_nxt = free_idx;
                lnk_nxt  = head_r;
                if (live(head_r)) state_nxt = ST_B;
                else begin
                  tail_nxt = free_idx;
                  fin      = 1'b1;
                end
              end else begin
                bwd_wd   = tail_r;
                tail_nxt = free_idx;
                lnk_nxt  = tail_r;
                if (live(tail_r)) state_nxt = ST_B;
                else begin
                  head_nxt = free_idx;
                  fin      = 1'b1;
                end
              end
            end
          end
          CMD_CUR_FIRST: begin
            cur_nxt = head_r;
            fin     = 1'b1;
          end
          CMD_CUR_LAST: begin
            cur_nxt = tail_r;
            fin     = 1'b1;
          end
          CMD_RD_FIRST: begin
            if (live(head_r)) rd_data = val_q;
            else err = 1'b1;
            fin = 1'b1;
          end
          CMD_RD_LAST: begin
            if (live(tail_r)) rd_data = val_q;
            else err = 1'b1;
            fin = 1'b1;
          end
          CMD_READ: begin
            if (live(cur_r)) rd_data = val_q;
            else err = 1'b1;
            fin = 1'b1;
          end
          CMD_DEL_FIRST: begin
            if (live(head_r)) begin
              if (cur_r == head_r) cur_nxt = NIL;
              if (live(fwd_q)) begin
                bwd_we = 1'b1;
                bwd_wa = fwd_q;
                bwd_wd = NIL;
              end else begin
                tail_nxt = NIL;
              end
              head_nxt = fwd_q;
              occ_nxt[head_r[AW-1:0]] = 1'b0;
              cnt_nxt = cnt_r - CW'(1);
            end
            fin = 1'b1;
          end
          CMD_DEL_LAST: begin
            if (live(tail_r)) begin
              if (cur_r == tail_r) cur_nxt = NIL;
              if (live(bwd_q)) begin
                fwd_we = 1'b1;
                fwd_wa = bwd_q;
                fwd_wd = NIL;
              end else begin
                head_nxt = NIL;
              end
              tail_nxt = bwd_q;
              occ_nxt[tail_r[AW-1:0]] = 1'b0;
              cnt_nxt = cnt_r - CW'(1);
            end
            fin = 1'b1;
          end
          CMD_DEL_AFTER: begin
            // fetch the successor's forward link next
            if (live(cur_r) && cur_r != tail_r && live(fwd_q)) begin
              lnk_nxt   = fwd_q;
              rd_en     = 1'b1;
              rd_addr   = fwd_q;
              state_nxt = ST_B;
            end else begin
              fin = 1'b1;
            end
          end
          CMD_DEL_BEFORE: begin
            if (live(cur_r) && cur_r != head_r && live(bwd_q)) begin
              lnk_nxt   = bwd_q;
              rd_en     = 1'b1;
              rd_addr   = bwd_q;
              state_nxt = ST_B;
            end else begin
              fin = 1'b1;
            end
          end
          CMD_INS_AFTER, CMD_INS_BEFORE: begin
            if (!live(cur_r)) begin
              fin = 1'b1;
            end else if (full) begin
              err = 1'b1;
              fin = 1'b1;
            end else begin
              val_we = 1'b1;
              fwd_we = 1'b1;
              bwd_we = 1'b1;
              occ_nxt[free_idx[AW-1:0]] = 1'b1;
              cnt_nxt   = cnt_r + CW'(1);
              state_nxt = ST_B;
              if (cmd_r == CMD_INS_AFTER) begin
                bwd_wd  = cur_r;
                fwd_wd  = fwd_q;
                lnk_nxt = fwd_q;
              end else begin
                fwd_wd  = cur_r;
                bwd_wd  = bwd_q;
                lnk_nxt = bwd_q;
              end
            end
          end
          CMD_WRITE: begin
            if (live(cur_r)) begin
              val_we = 1'b1;
              val_wa = cur_r;
            end
            fin = 1'b1;
          end
          CMD_NEXT: begin
            if (live(cur_r)) cur_nxt = fwd_q;
            fin = 1'b1;
          end
          CMD_PREV: begin
            if (live(cur_r)) cur_nxt = bwd_q;
            fin = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      ST_B: begin
        fin = 1'b1;
        case (cmd_r)
          CMD_INS_FIRST: begin
            bwd_we = 1'b1;
            bwd_wa = lnk_r;
            bwd_wd = new_r;
          end
          CMD_INS_LAST: begin
            fwd_we = 1'b1;
            fwd_wa = lnk_r;
            fwd_wd = new_r;
          end
          CMD_DEL_AFTER: begin
            // lnk_r is the entry being dropped, fwd_q its successor
            fwd_we = 1'b1;
            fwd_wa = cur_r;
            if (lnk_r == tail_r || !live(fwd_q)) begin
              tail_nxt = cur_r;
              fwd_wd   = NIL;
            end else begin
              bwd_we = 1'b1;
              bwd_wa = fwd_q;
              bwd_wd = cur_r;
              fwd_wd = fwd_q;
            end
            occ_nxt[lnk_r[AW-1:0]] = 1'b0;
            cnt_nxt = cnt_r - CW'(1);
          end
          CMD_DEL_BEFORE: begin
            bwd_we = 1'b1;
            bwd_wa = cur_r;
            if (lnk_r == head_r || !live(bwd_q)) begin
              head_nxt = cur_r;
              bwd_wd   = NIL;
            end else begin
              fwd_we = 1'b1;
              fwd_wa = bwd_q;
              fwd_wd = cur_r;
              bwd_wd = bwd_q;
            end
            occ_nxt[lnk_r[AW-1:0]] = 1'b0;
            cnt_nxt = cnt_r - CW'(1);
          end
          CMD_INS_AFTER: begin
            fwd_we = 1'b1;
            fwd_wa = cur_r;
            fwd_wd = new_r;
            if (live(lnk_r)) begin
              bwd_we = 1'b1;
              bwd_wa = lnk_r;
              bwd_wd = new_r;
            end else begin
              tail_nxt = new_r;
            end
          end
          CMD_INS_BEFORE: begin
            bwd_we = 1'b1;
            bwd_wa = cur_r;
            bwd_wd = new_r;
            if (live(lnk_r)) begin
              fwd_we = 1'b1;
              fwd_wa = lnk_r;
              fwd_wd = new_r;
            end else begin
              head_nxt = new_r;
            end
          end
          default: begin
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt              = ST_IDLE;
      out_valid_nxt          = 1'b1;
      out_nxt.read_data      = signed'(rd_data);
      out_nxt.error          = err;
      out_nxt.cursor_valid   = live(cur_nxt);
      out_nxt.list_empty     = !live(head_nxt);
      out_nxt.pool_full      = (cnt_nxt == CW'(NODES));
    end
  end

  // Memories: registered read, one write each per cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      val_q <= val_mem[rd_addr[AW-1:0]];
      fwd_q <= fwd_mem[rd_addr[AW-1:0]];
      bwd_q <= bwd_mem[rd_addr[AW-1:0]];
    end
    if (val_we) val_mem[val_wa[AW-1:0]] <= val_wd;
    if (fwd_we) fwd_mem[fwd_wa[AW-1:0]] <= fwd_wd;
    if (bwd_we) bwd_mem[bwd_wa[AW-1:0]] <= bwd_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= NIL;
      tail_r      <= NIL;
      cur_r       <= NIL;
      occ_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cur_r       <= cur_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    wval_r <= wval_nxt;
    new_r  <= new_nxt;
    lnk_r  <= lnk_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/dllce_checker.sv =====
// Port-level checker for the linked-list cursor engine, bound to the top level.
// Depends on dllce_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dllce_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic            out_valid,
  input dllce_pkg::out_t out_data
);
  import dllce_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // an accepted transaction holds off the next one
  `DLL_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "busy not raised after accept")
  // one result per command, never on consecutive cycles
  `DLL_ASSERT_NEXT(a_single_result, clk, rst_n, out_valid, !out_valid, "result repeated")
  // a result is shown only once the command has finished
  `DLL_ASSERT_NOW(a_result_idle, clk, rst_n, out_valid, !busy, "result while busy")
  // an empty list leaves no entry for the cursor and no full pool
  `DLL_ASSERT_NOW(a_empty_cursor, clk, rst_n, out_valid && out_data.list_empty,
    !out_data.cursor_valid && !out_data.pool_full, "cursor or full flag on empty list")
  // errors return no data
  `DLL_ASSERT_NOW(a_err_data, clk, rst_n, out_valid && out_data.error,
    out_data.read_data == 32'sd0, "read data on error")

endmodule

bind doubly_linked_list_cursor_engine_unit dllce_checker u_dllce_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for doubly_linked_list_cursor_engine_unit: clocked driver and monitor,
// an in-bench model of the pool-based list that predicts every status transaction.
// Depends on dllce_pkg (command codes, transaction structs) and the engine RTL.
module tb_top;
  import dllce_pkg::*;

  localparam int NODES = NODES_DEF;
  localparam logic [4:0] NIL = 5'(NODES);
  localparam int FUNC_MAX = 31;
  localparam int RANDOM_CMDS = 1450;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    in_t cmd;
    bit  hold_for_idle;
  } cmd_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  cmd_entry_t cmd_backlog[$];
  out_t       status_due_q[$];
  int         mismatch_cnt = 0;
  int         idle_left = 0;
  int         calm_left = 0;
  int         cycle_cnt = 0;

  // list model state
  logic signed [31:0] node_val [NODES];
  logic [4:0]         next_of [NODES];
  logic [4:0]         prev_of [NODES];
  logic [NODES-1:0]   in_use = '0;
  int unsigned        used_cnt = 0;
  logic [4:0]         head_idx = NIL;
  logic [4:0]         tail_idx = NIL;
  logic [4:0]         cur_idx = NIL;

  doubly_linked_list_cursor_engine_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Lowest free entry first; NIL when the pool is full.
  function automatic logic [4:0] grab_node(logic signed [31:0] v);
    for (int i = 0; i < NODES; i++) begin
      if (!in_use[i]) begin
        in_use[i] = 1'b1;
        used_cnt++;
        node_val[i] = v;
        next_of[i] = NIL;
        prev_of[i] = NIL;
        return 5'(i);
      end
    end
    return NIL;
  endfunction

  function automatic void release_node(logic [4:0] i);
    if (i != NIL && in_use[i]) begin
      in_use[i] = 1'b0;
      used_cnt--;
    end
  endfunction

  function automatic out_t list_step(in_t c);
    out_t       r;
    logic [4:0] a, b, n, p;
    r = '0;
    p = cur_idx;
    case (c.func)
      CMD_CLEAR: begin
        in_use = '0;
        used_cnt = 0;
        head_idx = NIL;
        tail_idx = NIL;
        cur_idx = NIL;
      end
      CMD_INS_FIRST: begin
        n = grab_node(c.value_in);
        if (n == NIL) r.error = 1'b1;
        else begin
          next_of[n] = head_idx;
          if (head_idx != NIL) prev_of[head_idx] = n;
          else tail_idx = n;
          head_idx = n;
        end
      end
      CMD_INS_LAST: begin
        n = grab_node(c.value_in);
        if (n == NIL) r.error = 1'b1;
        else begin
          prev_of[n] = tail_idx;
          if (tail_idx != NIL) next_of[tail_idx] = n;
          else head_idx = n;
          tail_idx = n;
        end
      end
      CMD_CUR_FIRST: cur_idx = head_idx;
      CMD_CUR_LAST:  cur_idx = tail_idx;
      CMD_RD_FIRST: begin
        if (head_idx != NIL) r.read_data = node_val[head_idx];
        else r.error = 1'b1;
      end
      CMD_RD_LAST: begin
        if (tail_idx != NIL) r.read_data = node_val[tail_idx];
        else r.error = 1'b1;
      end
      CMD_DEL_FIRST: begin
        a = head_idx;
        if (a != NIL) begin
          if (cur_idx == a) cur_idx = NIL;
          b = next_of[a];
          if (b != NIL) prev_of[b] = NIL;
          else tail_idx = NIL;
          head_idx = b;
          release_node(a);
        end
      end
      CMD_DEL_LAST: begin
        a = tail_idx;
        if (a != NIL) begin
          if (cur_idx == a) cur_idx = NIL;
          b = prev_of[a];
          if (b != NIL) next_of[b] = NIL;
          else head_idx = NIL;
          tail_idx = b;
          release_node(a);
        end
      end
      CMD_DEL_AFTER: begin
        if (p != NIL && p != tail_idx) begin
          a = next_of[p];
          if (a != NIL) begin
            b = next_of[a];
            if (a == tail_idx || b == NIL) begin
              tail_idx = p;
              next_of[p] = NIL;
            end else begin
              prev_of[b] = p;
              next_of[p] = b;
            end
            release_node(a);
          end
        end
      end
      CMD_DEL_BEFORE: begin
        if (p != NIL && p != head_idx) begin
          a = prev_of[p];
          if (a != NIL) begin
            b = prev_of[a];
            if (a == head_idx || b == NIL) begin
              head_idx = p;
              prev_of[p] = NIL;
            end else begin
              next_of[b] = p;
              prev_of[p] = b;
            end
            release_node(a);
          end
        end
      end
      CMD_INS_AFTER: begin
        if (p != NIL) begin
          n = grab_node(c.value_in);
          if (n == NIL) r.error = 1'b1;
          else begin
            b = next_of[p];
            prev_of[n] = p;
            next_of[n] = b;
            if (b != NIL) prev_of[b] = n;
            else tail_idx = n;
            next_of[p] = n;
          end
        end
      end
      CMD_INS_BEFORE: begin
        if (p != NIL) begin
          n = grab_node(c.value_in);
          if (n == NIL) r.error = 1'b1;
          else begin
            b = prev_of[p];
            next_of[n] = p;
            prev_of[n] = b;
            if (b != NIL) next_of[b] = n;
            else head_idx = n;
            prev_of[p] = n;
          end
        end
      end
      CMD_READ: begin
        if (p != NIL) r.read_data = node_val[p];
        else r.error = 1'b1;
      end
      CMD_WRITE: if (p != NIL) node_val[p] = c.value_in;
      CMD_NEXT:  if (p != NIL) cur_idx = next_of[p];
      CMD_PREV:  if (p != NIL) cur_idx = prev_of[p];
      default: ;
    endcase
    r.cursor_valid = (cur_idx != NIL);
    r.list_empty = (head_idx == NIL);
    r.pool_full = (used_cnt >= NODES);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      calm_left = $urandom_range(60, 10);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0;
      3:       return -32'sh1;
      default: return $urandom;
    endcase
  endfunction

  // kind: 0 grow the list, 1 shrink it, 2 walk the cursor, 3 noise
  function automatic logic [4:0] pick_func(int kind);
    int r;
    r = $urandom_range(99);
    case (kind)
      0: begin
        if (r < 35) return $urandom_range(1) ? CMD_INS_FIRST : CMD_INS_LAST;
        if (r < 70) return $urandom_range(1) ? CMD_INS_AFTER : CMD_INS_BEFORE;
        if (r < 85) return $urandom_range(1) ? CMD_CUR_FIRST : CMD_CUR_LAST;
      end
      1: begin
        if (r < 30) return $urandom_range(1) ? CMD_DEL_FIRST : CMD_DEL_LAST;
        if (r < 60) return $urandom_range(1) ? CMD_DEL_AFTER : CMD_DEL_BEFORE;
        if (r < 75) return $urandom_range(1) ? CMD_CUR_FIRST : CMD_CUR_LAST;
        if (r < 85) return $urandom_range(1) ? CMD_NEXT : CMD_PREV;
      end
      2: begin
        if (r < 30) return $urandom_range(1) ? CMD_NEXT : CMD_PREV;
        if (r < 45) return $urandom_range(1) ? CMD_CUR_FIRST : CMD_CUR_LAST;
        if (r < 65) return CMD_READ;
        if (r < 80) return CMD_WRITE;
        if (r < 90) return $urandom_range(1) ? CMD_RD_FIRST : CMD_RD_LAST;
      end
      default: begin
        if (r < 4) return CMD_CLEAR;
        if (r < 24) return 5'($urandom_range(FUNC_MAX, CMD_PREV + 1));
      end
    endcase
    return 5'($urandom_range(CMD_PREV, CMD_INS_FIRST));
  endfunction

  task automatic add_cmd(logic [4:0] f, logic signed [31:0] v, bit hold = 1'b0);
    cmd_entry_t e;
    e.cmd.func = f;
    e.cmd.value_in = v;
    e.hold_for_idle = hold;
    cmd_backlog.push_back(e);
  endtask

  // Driver: record the prediction for each accepted transaction, then launch the next one.
  always @(posedge clk) begin : drive_proc
    cmd_entry_t nxt;
    logic       taken;
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        status_due_q.push_back(list_step(in_data));
        idle_left = pick_gap();
      end
      if (start && !taken) begin
        // hold the transaction until busy drops
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (cmd_backlog.size() != 0 &&
                   !(cmd_backlog[0].hold_for_idle && status_due_q.size() != 0)) begin
        nxt = cmd_backlog.pop_front();
        in_data <= nxt.cmd;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_proc
    out_t want;
    if (rst_n && out_valid) begin
      if (status_due_q.size() == 0) begin
        $error("status transaction with none outstanding: %p", out_data);
        mismatch_cnt++;
      end else begin
        want = status_due_q.pop_front();
        if (out_data.read_data !== want.read_data) begin
          $error("read_data: expected %0d, got %0d", want.read_data, out_data.read_data);
          mismatch_cnt++;
        end
        if (out_data.error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, out_data.error);
          mismatch_cnt++;
        end
        if (out_data.cursor_valid !== want.cursor_valid) begin
          $error("cursor_valid: expected %0b, got %0b", want.cursor_valid,
                 out_data.cursor_valid);
          mismatch_cnt++;
        end
        if (out_data.list_empty !== want.list_empty) begin
          $error("list_empty: expected %0b, got %0b", want.list_empty, out_data.list_empty);
          mismatch_cnt++;
        end
        if (out_data.pool_full !== want.pool_full) begin
          $error("pool_full: expected %0b, got %0b", want.pool_full, out_data.pool_full);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stim_proc
    int count;
    int kind;
    int span;
    bit hold;

    // empty list and inactive cursor
    add_cmd(CMD_RD_FIRST, 0);
    add_cmd(CMD_RD_LAST, 0);
    add_cmd(CMD_READ, 0);
    add_cmd(CMD_DEL_FIRST, 0);
    add_cmd(CMD_DEL_LAST, 0);
    add_cmd(CMD_CUR_LAST, 0);
    add_cmd(CMD_NEXT, 0);
    add_cmd(CMD_PREV, 0);
    add_cmd(CMD_WRITE, 1);
    add_cmd(CMD_INS_AFTER, 5);
    add_cmd(CMD_DEL_AFTER, 0);
    // extremes, nothing before the head, losing the cursor off either end
    add_cmd(CMD_INS_FIRST, 32'sh7fff_ffff);
    add_cmd(CMD_INS_LAST, 32'sh8000_0000);
    add_cmd(CMD_CUR_FIRST, 0);
    add_cmd(CMD_DEL_BEFORE, 0);
    add_cmd(CMD_INS_BEFORE, -32'sh1);
    add_cmd(CMD_READ, 0);
    add_cmd(CMD_DEL_AFTER, 0);
    add_cmd(CMD_PREV, 0);
    add_cmd(CMD_PREV, 0);
    add_cmd(CMD_CUR_LAST, 0);
    add_cmd(CMD_WRITE, 0);
    add_cmd(CMD_RD_LAST, 0);
    add_cmd(CMD_DEL_LAST, 0);
    add_cmd(5'(FUNC_MAX), 32'sh5a5a_a5a5);
    add_cmd(CMD_CLEAR, 0);

    // random phases; the first one waits for the engine to go quiet
    count = 0;
    hold = 1'b1;
    while (count < RANDOM_CMDS) begin
      case ($urandom_range(99) / 10)
        0, 1, 2: kind = 0;
        3, 4, 5: kind = 1;
        6, 7, 8: kind = 2;
        default: kind = 3;
      endcase
      if (count == 0) kind = 0;
      span = (kind == 3) ? $urandom_range(12, 3) : $urandom_range(40, 10);
      for (int k = 0; k < span; k++) begin
        add_cmd(pick_func(kind), pick_value(), hold);
        hold = 1'b0;
        count++;
      end
      hold = ($urandom_range(7) == 0);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (cmd_backlog.size() != 0 || start || status_due_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
